FILE: hdl/mf16_pkg.sv
// Shared types and constants for the 16-bit minifloat adder.
`default_nettype none
package mf16_pkg;
	localparam int unsigned ExpW  = 6;
	localparam int unsigned FracW = 9;
	localparam int unsigned SigW  = 10;
	localparam logic [ExpW-1:0] ExpTop = 6'h3F;
	localparam logic [ExpW-1:0] MinExpReset = 6'd31;
	localparam logic [FracW-1:0] FracMax = 9'h1FF;
	localparam logic [0:0] RegMinExp = 1'b0;

	typedef struct packed {
		logic             sign;
		logic [ExpW-1:0]  exp;
		logic [FracW-1:0] frac;
	} mf16_t;
endpackage
`default_nettype wire

FILE: hdl/mf16_core.sv
// Combinational align, add or subtract, normalize and range check.
`default_nettype none
module mf16_core (
	input  wire logic [15:0] a,
	input  wire logic [15:0] b,
	input  wire logic [5:0]  min_exp,
	output logic      [15:0] sum
);
	mf16_pkg::mf16_t ua, ub;
	logic [5:0]  ea, eb, shift_amt;
	logic [9:0]  ma, mb, m;
	logic [10:0] add;
	logic [10:0] diff;
	logic [7:0]  e;
	logic        sign, zero;
	logic [3:0]  lz;

	always_comb begin
		ua = a;
		ub = b;
		ea = ua.exp;
		eb = ub.exp;
		ma = {1'b1, ua.frac};
		mb = {1'b1, ub.frac};
		if (ea > eb) begin
			shift_amt = ea - eb;
			mb = (shift_amt < 6'd16) ? (mb >> shift_amt[3:0]) : 10'd0;
			e = {2'b00, ea};
		end else begin
			shift_amt = eb - ea;
			ma = (shift_amt < 6'd16) ? (ma >> shift_amt[3:0]) : 10'd0;
			e = {2'b00, eb};
		end
		zero = 1'b0;
		lz = 4'd0;
		add = {1'b0, ma} + {1'b0, mb};
		diff = 11'd0;
		if (ua.sign == ub.sign) begin
			sign = ua.sign;
			if (add[10]) begin
				m = add[10:1];
				e = e + 8'd1;
			end else begin
				m = add[9:0];
			end
		end else begin
			diff = ub.sign ? ({1'b0, ma} - {1'b0, mb}) : ({1'b0, mb} - {1'b0, ma});
			sign = diff[10];
			if (diff[10]) diff = 11'd0 - diff;
			zero = (diff == 11'd0);
			for (int i = 9; i >= 0; i--) begin
				if (diff[i] && lz == 4'd0 && !(|(diff[9:0] >> (i + 1)))) lz = 4'(9 - i);
			end
			m = diff[9:0] << lz;
			e = e - {4'd0, lz};
		end
		if (zero) sum = 16'h0000;
		else if (!e[7] && e > 8'd63) sum = {sign, mf16_pkg::ExpTop, mf16_pkg::FracMax};
		else if (e[7] || e[5:0] < min_exp) sum = {sign, 15'd0};
		else sum = {sign, e[5:0], m[8:0]};
	end
endmodule
`default_nettype wire

FILE: hdl/minifloat16_adder_top.sv
// Top level of the 16-bit minifloat adder.
// Usage:
//  - Present operand_a and operand_b with start; accepted when start is high
//    and busy is low. busy is always low, so an item can enter every cycle.
//  - Operands are registered at the input; the core computes the sum and it
//    is registered at the output. sum_value with done passes through the
//    valid registers v_s1 and v_s2 after the accepting edge, for exactly one cycle.
//  - Throughput is one item per cycle, set by the single-pass core between
//    the input register and the result register.
//  - The receiver cannot stall; each result must be taken when done is high.
//  - min_exponent is written over the APB port at byte address 0; other
//    addresses read zero and ignore writes.
//  - Reset clears both valid stages and sets min_exponent to 31.
//  - Results below min_exponent flush to a signed zero; exponent overflow
//    saturates to the largest magnitude with the same sign.
`default_nettype none
module minifloat16_adder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] operand_a,
	input  wire logic [15:0] operand_b,
	output logic             done,
	output logic      [15:0] sum_value,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	logic [15:0] a_s1, b_s1, sum_s2, core_sum;
	logic        v_s1, v_s2;
	logic [5:0]  min_exp_q;
	logic        reg0;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign reg0   = (paddr[2] == mf16_pkg::RegMinExp) && (paddr[1:0] == 2'b00);
	assign prdata = reg0 ? {26'd0, min_exp_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_exp_q <= mf16_pkg::MinExpReset;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (psel && penable && pwrite && reg0) min_exp_q <= pwdata[5:0];
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_s1   <= operand_a;
		b_s1   <= operand_b;
		sum_s2 <= core_sum;
	end

	mf16_core u_core (.a(a_s1), .b(b_s1), .min_exp(min_exp_q), .sum(core_sum));

	assign done      = v_s2;
	assign sum_value = sum_s2;
endmodule
`default_nettype wire

FILE: hdl/mf16_checker.sv
// Port-level checker for the minifloat adder, bound to the top level.
`default_nettype none
module mf16_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [15:0] sum_value,
	input wire logic        pready
);
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done) else $error("item without result");
	a_nodone: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(start) && !$past(start, 2) |-> !done) else $error("result without item");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(sum_value)) else $error("unknown sum");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");
endmodule

bind minifloat16_adder_top mf16_checker u_chk (.clk(clk), .arst_n(arst_n), .start(start),
	.busy(busy), .done(done), .sum_value(sum_value), .pready(pready));
`default_nettype wire
